// File: rtl/crc16_frame_checker_macros.svh
// Assertion macros for the CRC-16 frame checker.
// Used by the top level; expects clk and rst in scope.
`ifndef CRC16_FRAME_CHECKER_MACROS_SVH
`define CRC16_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication, off during reset.
`define CRC16FC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define CRC16FC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/crc16fc_pkg.sv
// Shared types, constants and the byte-wide CRC-16/CCITT-FALSE update.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package crc16fc_pkg;

  localparam logic [15:0] CrcPoly   = 16'h1021;
  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcXorOut = 16'h0000;

  typedef logic [1:0] held_count_t;
  localparam held_count_t HeldNone = 2'd0;
  localparam held_count_t HeldOne  = 2'd1;
  localparam held_count_t HeldTwo  = 2'd2;

  typedef struct packed {
    logic        crc_ok;
    logic        frame_too_short;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
  } result_t;

  function automatic logic [15:0] fold_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/crc16fc_if.sv
// Valid/ready channel interfaces for frame bytes and check results.
// Depends on crc16fc_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface crc16fc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crc16fc_result_if;
  logic        valid;
  logic        ready;
  logic        crc_ok;
  logic        frame_too_short;
  logic [15:0] computed_crc;
  logic [15:0] received_crc;

  modport source (output valid, output crc_ok, output frame_too_short,
                  output computed_crc, output received_crc, input ready);
  modport sink (input valid, input crc_ok, input frame_too_short,
                input computed_crc, input received_crc, output ready);
endinterface
`default_nettype wire

// File: rtl/crc16fc_window.sv
// Two-byte holdback window and CRC accumulator; forms the result on a final beat.
// Depends on crc16fc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module crc16fc_window (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 last_byte,
  output logic                      result_valid,
  output crc16fc_pkg::result_t      result
);

  logic [15:0]              crc_acc, crc_acc_next;
  logic [7:0]               older, older_next;
  logic [7:0]               newer, newer_next;
  crc16fc_pkg::held_count_t held_count, held_count_next;
  logic [15:0]              computed;
  logic [15:0]              received;

  always_comb begin
    crc_acc_next    = crc_acc;
    older_next      = older;
    newer_next      = newer;
    held_count_next = held_count;
    unique case (held_count)
      crc16fc_pkg::HeldNone: begin
        older_next      = data_byte;
        held_count_next = crc16fc_pkg::HeldOne;
      end
      crc16fc_pkg::HeldOne: begin
        newer_next      = data_byte;
        held_count_next = crc16fc_pkg::HeldTwo;
      end
      default: begin
        crc_acc_next    = crc16fc_pkg::fold_byte(crc_acc, older);
        older_next      = newer;
        newer_next      = data_byte;
        held_count_next = crc16fc_pkg::HeldTwo;
      end
    endcase
  end

  assign computed = crc_acc_next ^ crc16fc_pkg::CrcXorOut;
  assign received = {newer_next, older_next};

  always_comb begin
    result_valid = accept && last_byte;
    result.computed_crc = computed;
    if (held_count == crc16fc_pkg::HeldNone) begin
      result.crc_ok          = 1'b0;
      result.frame_too_short = 1'b1;
      result.received_crc    = 16'h0000;
    end else begin
      result.crc_ok          = (computed == received);
      result.frame_too_short = 1'b0;
      result.received_crc    = received;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      crc_acc    <= crc16fc_pkg::CrcInit;
      older      <= 8'h00;
      newer      <= 8'h00;
      held_count <= crc16fc_pkg::HeldNone;
    end else if (accept) begin
      crc_acc    <= crc_acc_next;
      older      <= older_next;
      newer      <= newer_next;
      held_count <= held_count_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/crc16fc_out_queue.sv
// Two-entry result register; takes a new result while an older one waits.
// Depends on crc16fc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module crc16fc_out_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire crc16fc_pkg::result_t push_data,
  output logic                      has_room,
  output logic                      front_valid,
  output crc16fc_pkg::result_t      front,
  input  wire logic                 pop
);

  crc16fc_pkg::result_t entry0;
  crc16fc_pkg::result_t entry1;
  logic [1:0]           count;
  logic [1:0]           count_after_pop;

  assign front_valid     = (count != 2'd0);
  assign has_room        = (count != 2'd2);
  assign front           = entry0;
  assign count_after_pop = count - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_after_pop + {1'b0, push};
    end
  end

  always_ff @(posedge clk) begin
    if (pop && count == 2'd2) begin
      entry0 <= entry1;
    end
    if (push) begin
      if (count_after_pop == 2'd0) begin
        entry0 <= push_data;
      end else begin
        entry1 <= push_data;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/crc16_frame_checker.sv
// CRC-16/CCITT-FALSE frame checker. Takes one frame byte per beat; the two
// newest bytes are held back and every older byte is folded into the CRC
// (poly 0x1021, init 0xFFFF). On the final byte it reports whether the CRC
// matches the trailing two bytes (last byte high), flags frames shorter than
// two bytes, and restarts. One byte per cycle sustained while a result entry
// is free; the byte-wide CRC update sits between the window registers and a
// two-entry result register, which takes the result as its final byte is
// accepted. Input ready drops only while both result entries are held.
// Depends on crc16fc_pkg, crc16fc_if, crc16fc_window, crc16fc_out_queue.
`timescale 1ns / 1ps
`default_nettype none
`include "crc16_frame_checker_macros.svh"
module crc16_frame_checker (
  input  wire logic  clk,
  input  wire logic  rst,
  crc16fc_byte_if.sink     byte_in,
  crc16fc_result_if.source result_out
);

  logic                 accept;
  logic                 result_valid;
  crc16fc_pkg::result_t result;
  crc16fc_pkg::result_t front;
  logic                 has_room;
  logic                 front_valid;

  assign byte_in.ready = has_room;
  assign accept        = byte_in.valid && has_room;

  crc16fc_window u_window (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (byte_in.data_byte),
    .last_byte    (byte_in.last_byte),
    .result_valid (result_valid),
    .result       (result)
  );

  crc16fc_out_queue u_out_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (result_valid),
    .push_data   (result),
    .has_room    (has_room),
    .front_valid (front_valid),
    .front       (front),
    .pop         (result_out.valid && result_out.ready)
  );

  assign result_out.valid           = front_valid;
  assign result_out.crc_ok          = front.crc_ok;
  assign result_out.frame_too_short = front.frame_too_short;
  assign result_out.computed_crc    = front.computed_crc;
  assign result_out.received_crc    = front.received_crc;

  `CRC16FC_ASSERT_SAME(a_short_not_ok, result_out.valid && result_out.frame_too_short, !result_out.crc_ok && result_out.received_crc == 16'h0000, "short frame reported as ok")
  `CRC16FC_ASSERT_SAME(a_ok_matches, result_out.valid && !result_out.frame_too_short, result_out.crc_ok == (result_out.computed_crc == result_out.received_crc), "crc_ok disagrees with compare")
  `CRC16FC_ASSERT_NEXT(a_final_beat_result, byte_in.valid && byte_in.ready && byte_in.last_byte, result_out.valid, "final beat gave no result")

endmodule
`default_nettype wire
